FILE: sv/zcid_pkg.sv
// ----------------------------------------------------------------------------
// zcid_pkg
// Types, constants and state/command codes shared by the zero-curve
// interpolation and discount block.
// ----------------------------------------------------------------------------
package zcid_pkg;

  localparam int MAX_PILLARS = 16;
  localparam int IDX_W       = $clog2(MAX_PILLARS);
  localparam int CNT_W       = $clog2(MAX_PILLARS + 1);

  localparam logic [35:0]        LN2_Q30  = 36'd744261118;
  localparam logic signed [43:0] Y30_LO   = -44'sd29026183602;
  localparam logic signed [43:0] Y30_LO_P = 44'sd29026183602;
  localparam logic signed [43:0] Y30_HI   = 44'sd1488522236;
  localparam logic [32:0]        Q30_ONE  = 33'd1073741824;
  localparam logic [3:0]         TERMS    = 4'd14;
  localparam logic [5:0]         K_BIAS   = 6'd39;

  typedef struct packed {
    logic               kind;
    logic [3:0]         entry_index;
    logic [23:0]        pillar_time;
    logic signed [31:0] pillar_rate;
    logic [23:0]        query_time;
  } zcid_in_t;

  typedef struct packed {
    logic signed [31:0] rate_out;
    logic [31:0]        discount_out;
    logic               saturated;
    logic               status;
  } zcid_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SEL, ST_IMUL, ST_DINIT, ST_DIV, ST_RATE, ST_XMUL,
    ST_Y30, ST_RINIT, ST_RED, ST_HMUL, ST_HRCP, ST_HFIX, ST_SCALE, ST_OUT
  } zcid_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_START, OP_SCAN, OP_SEL, OP_IMUL, OP_DINIT, OP_DIV,
    OP_RATE, OP_XMUL, OP_Y30, OP_RINIT, OP_RED, OP_HMUL, OP_HRCP, OP_HFIX,
    OP_SCALE, OP_OUT
  } zcid_op_t;

  typedef struct packed {
    zcid_op_t op;
  } zcid_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic bad;
    logic interp;
    logic div_done;
    logic red_done;
    logic horner_last;
    logic out_free;
  } zcid_stat_t;

  function automatic logic [32:0] recip(input logic [3:0] j);
    logic [32:0] r;
    case (j)
      4'd1:    r = 33'd4294967296;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      4'd11:   r = 33'd390451572;
      4'd12:   r = 33'd357913941;
      4'd13:   r = 33'd330382099;
      4'd14:   r = 33'd306783378;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/zcid_ctrl.sv
// ----------------------------------------------------------------------------
// zcid_ctrl
// Sequencer: takes loads, and steps a query through scan, interpolation or
// flat select, exponential and output, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module zcid_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 kind,
  input  zcid_pkg::zcid_stat_t stat,
  output logic                 in_ready,
  output zcid_pkg::zcid_cmd_t  cmd
);

  zcid_pkg::zcid_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zcid_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      zcid_pkg::ST_IDLE: begin
        if (in_valid && kind) state_next = zcid_pkg::ST_SCAN;
      end
      zcid_pkg::ST_SCAN: begin
        if (stat.scan_done) begin
          if (stat.bad)         state_next = zcid_pkg::ST_OUT;
          else if (stat.interp) state_next = zcid_pkg::ST_IMUL;
          else                  state_next = zcid_pkg::ST_SEL;
        end
      end
      zcid_pkg::ST_SEL:   state_next = zcid_pkg::ST_XMUL;
      zcid_pkg::ST_IMUL:  state_next = zcid_pkg::ST_DINIT;
      zcid_pkg::ST_DINIT: state_next = zcid_pkg::ST_DIV;
      zcid_pkg::ST_DIV: begin
        if (stat.div_done) state_next = zcid_pkg::ST_RATE;
      end
      zcid_pkg::ST_RATE:  state_next = zcid_pkg::ST_XMUL;
      zcid_pkg::ST_XMUL:  state_next = zcid_pkg::ST_Y30;
      zcid_pkg::ST_Y30:   state_next = zcid_pkg::ST_RINIT;
      zcid_pkg::ST_RINIT: state_next = zcid_pkg::ST_RED;
      zcid_pkg::ST_RED: begin
        if (stat.red_done) state_next = zcid_pkg::ST_HMUL;
      end
      zcid_pkg::ST_HMUL:  state_next = zcid_pkg::ST_HRCP;
      zcid_pkg::ST_HRCP:  state_next = zcid_pkg::ST_HFIX;
      zcid_pkg::ST_HFIX: begin
        state_next = stat.horner_last ? zcid_pkg::ST_SCALE : zcid_pkg::ST_HMUL;
      end
      zcid_pkg::ST_SCALE: state_next = zcid_pkg::ST_OUT;
      zcid_pkg::ST_OUT: begin
        if (stat.out_free) state_next = zcid_pkg::ST_IDLE;
      end
      default: state_next = zcid_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = zcid_pkg::OP_NONE;
    case (state)
      zcid_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = kind ? zcid_pkg::OP_START : zcid_pkg::OP_LOAD;
      end
      zcid_pkg::ST_SCAN:  cmd.op = zcid_pkg::OP_SCAN;
      zcid_pkg::ST_SEL:   cmd.op = zcid_pkg::OP_SEL;
      zcid_pkg::ST_IMUL:  cmd.op = zcid_pkg::OP_IMUL;
      zcid_pkg::ST_DINIT: cmd.op = zcid_pkg::OP_DINIT;
      zcid_pkg::ST_DIV:   cmd.op = zcid_pkg::OP_DIV;
      zcid_pkg::ST_RATE:  cmd.op = zcid_pkg::OP_RATE;
      zcid_pkg::ST_XMUL:  cmd.op = zcid_pkg::OP_XMUL;
      zcid_pkg::ST_Y30:   cmd.op = zcid_pkg::OP_Y30;
      zcid_pkg::ST_RINIT: cmd.op = zcid_pkg::OP_RINIT;
      zcid_pkg::ST_RED:   cmd.op = zcid_pkg::OP_RED;
      zcid_pkg::ST_HMUL:  cmd.op = zcid_pkg::OP_HMUL;
      zcid_pkg::ST_HRCP:  cmd.op = zcid_pkg::OP_HRCP;
      zcid_pkg::ST_HFIX:  cmd.op = zcid_pkg::OP_HFIX;
      zcid_pkg::ST_SCALE: cmd.op = zcid_pkg::OP_SCALE;
      zcid_pkg::ST_OUT: begin
        if (stat.out_free) cmd.op = zcid_pkg::OP_OUT;
      end
      default: cmd.op = zcid_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: sv/zcid_dp.sv
// ----------------------------------------------------------------------------
// zcid_dp
// Datapath: pillar memories, table scan, serial divider for the rate step,
// range reduction and Horner series for exp, and the output register.
// ----------------------------------------------------------------------------
module zcid_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  zcid_pkg::zcid_cmd_t  cmd,
  input  zcid_pkg::zcid_in_t   in_data,
  input  logic                 cfg_we,
  input  logic [4:0]           cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output zcid_pkg::zcid_out_t  out_data,
  output zcid_pkg::zcid_stat_t stat
);

  logic [23:0]        mat_mem  [zcid_pkg::MAX_PILLARS];
  logic signed [31:0] rate_mem [zcid_pkg::MAX_PILLARS];
  logic [23:0]        rd_mat;
  logic signed [31:0] rd_rate;

  logic [4:0]                 pillar_count;
  logic [zcid_pkg::CNT_W-1:0] n_use;
  logic [zcid_pkg::CNT_W-1:0] scan_idx;
  logic [zcid_pkg::IDX_W-1:0] proc_idx;
  logic                       pend;
  logic                       bad;
  logic                       found;

  logic [23:0]        qt;
  logic [23:0]        first_m, prev_m, last_m, t0, t1;
  logic signed [31:0] first_z, prev_z, last_z, z0, z1;

  logic signed [57:0] num;
  logic               neg;
  logic [23:0]        rem;
  logic [32:0]        qr;
  logic [5:0]         div_cnt;
  logic [24:0]        trial;
  logic               trial_ge;

  logic signed [31:0] rate;
  logic signed [56:0] xprod;
  logic signed [43:0] y30;
  logic signed [57:0] ysum;
  logic signed [43:0] wsum;
  logic [35:0]        w;
  logic [35:0]        red_sh;
  logic [5:0]         kq;
  logic [2:0]         red_bit;
  logic               under, satf;

  logic [32:0]        p;
  logic [3:0]         j;
  logic [62:0]        hprod;
  logic [32:0]        v;
  logic [65:0]        m;
  logic [32:0]        q_est, q_inc;
  logic [36:0]        q_chk;

  logic [5:0]         shr;
  logic [40:0]        scaled;
  logic [31:0]        disc;
  logic               sat_r;

  logic signed [33:0] q_signed;
  logic signed [33:0] rate_sum;

  always_comb begin
    if (pillar_count > 5'(zcid_pkg::MAX_PILLARS)) n_use = zcid_pkg::CNT_W'(zcid_pkg::MAX_PILLARS);
    else                                          n_use = zcid_pkg::CNT_W'(pillar_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pillar_count <= 5'd1;
    end else if (cfg_we) begin
      pillar_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == zcid_pkg::OP_LOAD) begin
      mat_mem[in_data.entry_index]  <= in_data.pillar_time;
      rate_mem[in_data.entry_index] <= in_data.pillar_rate;
    end
    rd_mat  <= mat_mem[scan_idx[zcid_pkg::IDX_W-1:0]];
    rd_rate <= rate_mem[scan_idx[zcid_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      scan_idx <= '0;
    end else if (cmd.op == zcid_pkg::OP_START) begin
      pend     <= 1'b0;
      scan_idx <= '0;
    end else if (cmd.op == zcid_pkg::OP_SCAN) begin
      pend <= (scan_idx < n_use);
      if (scan_idx < n_use) scan_idx <= scan_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      zcid_pkg::OP_START: begin
        qt    <= in_data.query_time;
        bad   <= (n_use == '0);
        found <= 1'b0;
      end
      zcid_pkg::OP_SCAN: begin
        proc_idx <= scan_idx[zcid_pkg::IDX_W-1:0];
        if (pend) begin
          if (proc_idx == '0) begin
            first_m <= rd_mat;
            first_z <= rd_rate;
          end else begin
            if (rd_mat <= prev_m) bad <= 1'b1;
            if (!found && rd_mat >= qt) begin
              found <= 1'b1;
              t0    <= prev_m;
              z0    <= prev_z;
              t1    <= rd_mat;
              z1    <= rd_rate;
            end
          end
          prev_m <= rd_mat;
          prev_z <= rd_rate;
          last_m <= rd_mat;
          last_z <= rd_rate;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.scan_done   = !pend && (scan_idx >= n_use);
    stat.bad         = bad;
    stat.interp      = (qt > first_m) && (qt < last_m);
    stat.div_done    = (div_cnt == 6'd32);
    stat.red_done    = (red_bit == 3'd0);
    stat.horner_last = (j == 4'd1);
    stat.out_free    = !out_valid || out_ready;
  end

  always_comb begin
    trial    = {rem, qr[32]};
    trial_ge = (trial >= {1'b0, t1 - t0});
    q_signed = neg ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
    rate_sum = $signed({{2{z0[31]}}, z0}) + q_signed;
    ysum     = -$signed({xprod[56], xprod}) + 58'sd8192;
    wsum     = y30 + zcid_pkg::Y30_LO_P;
    red_sh   = zcid_pkg::LN2_Q30 << red_bit;
    q_est    = m[64:32];
    q_inc    = q_est + 33'd1;
    q_chk    = q_inc * j;
    shr      = zcid_pkg::K_BIAS - kq;
    if (kq == zcid_pkg::K_BIAS + 6'd1)  scaled = {7'd0, p, 1'b0};
    else if (kq >= zcid_pkg::K_BIAS)    scaled = {8'd0, p};
    else scaled = ({8'd0, p} + (41'd1 << (shr - 6'd1))) >> shr;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      zcid_pkg::OP_SEL: begin
        rate <= (qt <= first_m) ? first_z : last_z;
      end
      zcid_pkg::OP_IMUL: begin
        num <= $signed({1'b0, qt - t0}) * ($signed({z1[31], z1}) - $signed({z0[31], z0}));
      end
      zcid_pkg::OP_DINIT: begin
        neg     <= num[57];
        rem     <= num[57] ? 24'((-num) >>> 33) : num[56:33];
        qr      <= num[57] ? 33'(-num) : num[32:0];
        div_cnt <= '0;
      end
      zcid_pkg::OP_DIV: begin
        rem     <= trial_ge ? 24'(trial - {1'b0, t1 - t0}) : trial[23:0];
        qr      <= {qr[31:0], trial_ge};
        div_cnt <= div_cnt + 6'd1;
      end
      zcid_pkg::OP_RATE: begin
        rate <= rate_sum[31:0];
      end
      zcid_pkg::OP_XMUL: begin
        xprod <= rate * $signed({1'b0, qt});
      end
      zcid_pkg::OP_Y30: begin
        y30 <= ysum[57:14];
      end
      zcid_pkg::OP_RINIT: begin
        under   <= (y30 < zcid_pkg::Y30_LO);
        satf    <= (y30 >= zcid_pkg::Y30_HI);
        w       <= wsum[35:0];
        kq      <= '0;
        red_bit <= 3'd5;
        p       <= zcid_pkg::Q30_ONE;
        j       <= zcid_pkg::TERMS;
      end
      zcid_pkg::OP_RED: begin
        if (w >= red_sh) begin
          w           <= w - red_sh;
          kq[red_bit] <= 1'b1;
        end
        red_bit <= red_bit - 3'd1;
      end
      zcid_pkg::OP_HMUL: begin
        hprod <= w[29:0] * p;
      end
      zcid_pkg::OP_HRCP: begin
        v <= hprod[62:30];
        m <= hprod[62:30] * zcid_pkg::recip(j);
      end
      zcid_pkg::OP_HFIX: begin
        p <= zcid_pkg::Q30_ONE + ((q_chk <= {4'd0, v}) ? q_inc : q_est);
        j <= j - 4'd1;
      end
      zcid_pkg::OP_SCALE: begin
        if (under) begin
          disc  <= '0;
          sat_r <= 1'b0;
        end else if (satf || kq > zcid_pkg::K_BIAS + 6'd1 || scaled[40:32] != '0) begin
          disc  <= '1;
          sat_r <= 1'b1;
        end else begin
          disc  <= scaled[31:0];
          sat_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == zcid_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == zcid_pkg::OP_OUT) begin
      if (bad) begin
        out_data <= '{rate_out: '0, discount_out: '0, saturated: 1'b0, status: 1'b1};
      end else begin
        out_data <= '{rate_out: rate, discount_out: disc, saturated: sat_r, status: 1'b0};
      end
    end
  end

endmodule

FILE: sv/zero_curve_interp_discount.sv
// ----------------------------------------------------------------------------
// zero_curve_interp_discount
// Zero-curve pillar table with linear rate interpolation (flat outside the
// pillars) and discount factor exp(-rate*t) in Q2.30.
//
//   channel   dir   handshake            payload
//   in        in    in_valid/in_ready    zcid_in_t
//   out       out   out_valid/out_ready  zcid_out_t
//   cfg       in    cfg_we               cfg_data (pillar_count)
//
// A load transfer leaves the block idle and ready for the next item.
// A query passes through the table scan, the serial divider when the point
// lies between pillars, the exponent product and range reduction and the
// 14-term Horner series, then the output transfer.
// The result register frees the input side; a stalled output holds only the
// next finished query. Reset is synchronous; table contents are kept.
// ----------------------------------------------------------------------------
module zero_curve_interp_discount (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  zcid_pkg::zcid_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output zcid_pkg::zcid_out_t out_data,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_data
);

  zcid_pkg::zcid_cmd_t  cmd;
  zcid_pkg::zcid_stat_t stat;

  zcid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (in_data.kind),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  zcid_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule

FILE: sv/zcid_checker.sv
// ----------------------------------------------------------------------------
// zcid_checker
// Port-level checks for the zero-curve block, bound to the top level.
// ----------------------------------------------------------------------------
module zcid_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input zcid_pkg::zcid_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input zcid_pkg::zcid_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.kind |=> !in_ready)
    else $error("input ready right after a query transfer");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |->
      out_data.rate_out == '0 && out_data.discount_out == '0 && !out_data.saturated)
    else $error("invalid-table result carries data");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |-> out_data.discount_out == '1)
    else $error("saturated result below maximum");

endmodule

bind zero_curve_interp_discount zcid_checker u_zcid_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for zero_curve_interp_discount. Loads curve pillars, writes the
// pillar count over several settings and queries the curve with bursty input
// and a stalling output. A scoreboard predicts each query's rate, discount
// factor, saturation flag and status, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam longint L2_Q30     = 744261118;
  localparam longint UNIT_Q30   = longint'(1) << 30;
  localparam int     SETTLE     = 250;
  localparam int     CYCLE_CAP  = 3000000;
  localparam int     ITEM_GOAL  = 1250;
  localparam logic   KIND_LOAD  = 1'b0;
  localparam logic   KIND_QUERY = 1'b1;

  class curve_board;
    logic [23:0]         mat[zcid_pkg::MAX_PILLARS];
    logic signed [31:0]  zr[zcid_pkg::MAX_PILLARS];
    logic [4:0]          count;
    zcid_pkg::zcid_out_t awaited[$];
    int                  errors;

    function new();
      count  = 5'd1;
      errors = 0;
    endfunction

    function longint fdiv(longint v, longint d);
      if (v >= 0) return v / d;
      return -((-v + d - 1) / d);
    endfunction

    function zcid_pkg::zcid_out_t predict(logic [23:0] t);
      zcid_pkg::zcid_out_t res;
      int                  n, i;
      bit                  bad;
      longint              rate, t0, t1, z0, z1, y, y30, k;
      longint unsigned     r, p;
      n   = (count > zcid_pkg::MAX_PILLARS) ? zcid_pkg::MAX_PILLARS : count;
      bad = (n == 0);
      for (i = 1; i < n; i++) if (mat[i] <= mat[i-1]) bad = 1;
      res = '0;
      if (bad) begin
        res.status = 1'b1;
        return res;
      end
      if (t <= mat[0]) rate = longint'(zr[0]);
      else if (t >= mat[n-1]) rate = longint'(zr[n-1]);
      else begin
        for (i = 1; i < n - 1; i++) if (mat[i] >= t) break;
        t0 = longint'(mat[i-1]);
        t1 = longint'(mat[i]);
        z0 = longint'(zr[i-1]);
        z1 = longint'(zr[i]);
        rate = z0 + ((longint'(t) - t0) * (z1 - z0)) / (t1 - t0);
      end
      res.rate_out = rate[31:0];
      y   = -(rate * longint'(t));
      y30 = fdiv(y + 8192, 16384);
      k   = fdiv(y30, L2_Q30);
      r   = y30 - k * L2_Q30;
      p   = UNIT_Q30;
      for (i = 14; i >= 1; i--) p = UNIT_Q30 + (r * p) / (longint'(i) << 30);
      if (k >= 2) p = 64'h1_0000_0000;
      else if (k == 1) p = p << 1;
      else if (k < 0) begin
        if (-k >= 40) p = 0;
        else p = (p + (64'd1 << (-k - 1))) >> (-k);
      end
      if (p > 64'hFFFF_FFFF) begin
        res.saturated    = 1'b1;
        res.discount_out = 32'hFFFF_FFFF;
      end else begin
        res.discount_out = p[31:0];
      end
      return res;
    endfunction

    function void note_item(zcid_pkg::zcid_in_t it);
      if (it.kind == KIND_LOAD) begin
        mat[it.entry_index] = it.pillar_time;
        zr[it.entry_index]  = it.pillar_rate;
      end else begin
        awaited = {awaited, predict(it.query_time)};
      end
    endfunction

    function void check_result(zcid_pkg::zcid_out_t got);
      zcid_pkg::zcid_out_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result rate %0d discount %0h", $time, got.rate_out,
                 got.discount_out);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.rate_out !== want.rate_out) begin
        $display("%0t: rate_out expected %0d actual %0d", $time, want.rate_out,
                 got.rate_out);
        errors++;
      end
      if (got.discount_out !== want.discount_out) begin
        $display("%0t: discount_out expected %0h actual %0h", $time, want.discount_out,
                 got.discount_out);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %0b actual %0b", $time, want.saturated,
                 got.saturated);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0b actual %0b", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic      clk, rst;
  logic      in_valid, in_ready, out_valid, out_ready, cfg_we;
  logic [4:0] cfg_data;
  zcid_pkg::zcid_in_t  in_data;
  zcid_pkg::zcid_out_t out_data;

  curve_board board;
  int  cycles;
  int  burst_left;
  int  items;
  bit  hold_go;

  zero_curve_interp_discount dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: stall pattern plus one long hold-off
  int  rx_mode, rx_left, hold_left;
  bit  hold_done;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(8, 120);
    end else rx_left--;
    if (hold_go && !hold_done) begin
      hold_done = 1;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic push_item(zcid_pkg::zcid_in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(it);
    items++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_count(logic [4:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    board.count = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic zcid_pkg::zcid_in_t make_load(int idx, logic [23:0] t, logic [31:0] z);
    zcid_pkg::zcid_in_t it;
    it             = zcid_pkg::zcid_in_t'({$urandom, $urandom, $urandom});
    it.kind        = KIND_LOAD;
    it.entry_index = idx[3:0];
    it.pillar_time = t;
    it.pillar_rate = z;
    return it;
  endfunction

  function automatic zcid_pkg::zcid_in_t make_query(logic [23:0] t);
    zcid_pkg::zcid_in_t it;
    it            = zcid_pkg::zcid_in_t'({$urandom, $urandom, $urandom});
    it.kind       = KIND_QUERY;
    it.query_time = t;
    return it;
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'd0;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
    endcase
  endfunction

  function automatic logic [23:0] pick_query(int n);
    int i;
    case ($urandom_range(0, 7))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      2: begin
        i = $urandom_range(0, (n > 0) ? ((n > 16 ? 16 : n) - 1) : 0);
        return board.mat[i] + 24'($urandom_range(0, 2)) - 24'd1;
      end
      3: return 24'($urandom);
      default: return 24'($urandom_range(0, 24'h0A_0000));
    endcase
  endfunction

  initial begin
    int          i, m, n, q, stepmax;
    logic [23:0] t;
    board      = new();
    cycles     = 0;
    items      = 0;
    hold_go    = 0;
    hold_done  = 0;
    hold_left  = 0;
    rx_left    = 0;
    burst_left = 10;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_data   = 5'd1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: fill every slot, extremes at both ends
    push_item(make_load(0, 24'd0, 32'h8000_0000));
    for (i = 1; i < 15; i++) push_item(make_load(i, 24'(i * 24'h01_0000), pick_rate()));
    push_item(make_load(15, 24'hFF_FFFF, 32'h7FFF_FFFF));
    push_item(make_query(24'd0));
    push_item(make_query(24'hFF_FFFF));
    set_count(5'd16);
    push_item(make_query(board.mat[5]));
    push_item(make_query(24'h05_8000));
    push_item(make_query(24'hFF_FFFF));
    push_item(make_query(24'h00_0001));
    set_count(5'd0);
    push_item(make_query(24'h01_0000));
    set_count(5'd31);
    push_item(make_query(24'h03_4000));

    while (items < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0: n = 0;
        1: n = $urandom_range(17, 31);
        2: n = 16;
        3: n = 1;
        default: n = $urandom_range(2, 16);
      endcase
      set_count(5'(n));
      m = (n > 16) ? 16 : n;
      if ($urandom_range(0, 4) == 0) begin
        for (i = 0; i < m; i++) push_item(make_load(i, 24'($urandom), pick_rate()));
      end else begin
        stepmax = ($urandom_range(0, 2) == 0) ? 24'hFF_FFFF / (m + 1) : 24'h02_0000;
        t = 24'($urandom_range(0, stepmax));
        for (i = 0; i < m; i++) begin
          push_item(make_load(i, t, pick_rate()));
          t = t + 24'($urandom_range(1, stepmax));
        end
      end
      for (q = 0; q < 60; q++) begin
        if (q == 20 && !hold_go && items > 400) hold_go = 1;
        if ($urandom_range(0, 29) == 0)
          push_item(make_load($urandom_range(0, 15), 24'($urandom), pick_rate()));
        else
          push_item(make_query(pick_query(n)));
      end
    end

    drain();
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
